// ===== sv/dual_order_task_queue_macros.svh =====
// Assertion macros shared by the task queue modules
`ifndef DUAL_ORDER_TASK_QUEUE_MACROS_SVH
`define DUAL_ORDER_TASK_QUEUE_MACROS_SVH
// check that a condition implies a consequence in the same cycle
`define DOTQ_ASSERT_IMP(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("label failed");
// check that a condition implies a consequence in the next cycle
`define DOTQ_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("label failed");
`endif

// ===== sv/dotq_pkg.sv =====
`default_nettype none
package dotq_pkg;
  localparam int DepthDefault = 16;
  localparam int PrioBitsDefault = 8;
  localparam int ArrBits = 17;

  localparam logic [3:0] ActInsert  = 4'd0;
  localparam logic [3:0] ActPopP    = 4'd1;
  localparam logic [3:0] ActPopT    = 4'd2;
  localparam logic [3:0] ActPeekP   = 4'd3;
  localparam logic [3:0] ActPeekT   = 4'd4;
  localparam logic [3:0] ActListP   = 4'd5;
  localparam logic [3:0] ActListT   = 4'd6;
  localparam logic [3:0] ActChgP    = 4'd7;
  localparam logic [3:0] ActChgT    = 4'd8;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StEmpty    = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  // datapath operations, one per controller step
  typedef enum logic [3:0] {
    OpNone, OpLoad, OpFindFree, OpWriteSlot, OpScan, OpRemove, OpPlace,
    OpWriteKey, OpEmit, OpFree
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   sel_time;  // work on the time order
    logic   use_new;   // scan keys at the new value
    logic   match;     // scan for an exact match instead of a place
  } dp_cmd_t;

  typedef struct packed {
    logic done;      // scan or sweep finished
    logic found;     // scan matched
    logic empty;
    logic full;
    logic last_item; // emit index reached final entry
  } dp_stat_t;

  function automatic logic [ArrBits-1:0] arrival(input logic [4:0] h, input logic [5:0] m,
                                                 input logic [5:0] s);
    arrival = ArrBits'(h) * ArrBits'(3600) + ArrBits'(m) * ArrBits'(60) + ArrBits'(s);
  endfunction
endpackage
`default_nettype wire

// ===== sv/dotq_datapath.sv =====
`default_nettype none
module dotq_datapath import dotq_pkg::*; #(
  parameter int DEPTH = DepthDefault,
  parameter int PRIORITY_BITS = PrioBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat,
  input  wire logic [76:0] req,
  output logic [40:0]      res_data
);
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [PRIORITY_BITS-1:0] s_prio [DEPTH];
  logic [4:0]   s_h [DEPTH];
  logic [5:0]   s_m [DEPTH];
  logic [5:0]   s_s [DEPTH];
  logic [ArrBits-1:0] s_arr [DEPTH];
  logic [15:0]  s_tag [DEPTH];
  logic [DEPTH-1:0] used;
  logic [IW-1:0] p_ord [DEPTH];
  logic [IW-1:0] t_ord [DEPTH];
  logic [CW-1:0] count;

  // request register fields
  logic [76:0] r;
  logic [3:0] r_act;
  logic [PRIORITY_BITS-1:0] key_p, new_p;
  logic [ArrBits-1:0] key_t, new_t;
  logic [IW-1:0] slot, idx;
  logic [CW-1:0] ptr, n;
  logic found;

  assign r_act = r[3:0];
  assign key_p = PRIORITY_BITS'(r[11:4]);
  assign new_p = PRIORITY_BITS'(r[52:45]);
  assign key_t = arrival(r[16:12], r[22:17], r[28:23]);
  assign new_t = arrival(r[57:53], r[63:58], r[69:64]);

  logic [IW-1:0] cur;
  logic scan_hit;
  assign cur = cmd.sel_time ? t_ord[ptr[IW-1:0]] : p_ord[ptr[IW-1:0]];
  always_comb begin
    if (cmd.match)
      scan_hit = cmd.sel_time ? (s_arr[cur] == key_t) : (s_prio[cur] == key_p);
    else if (cmd.sel_time)
      scan_hit = !(s_arr[cur] < (cmd.use_new ? new_t : key_t));
    else
      scan_hit = !(s_prio[cur] > (cmd.use_new ? new_p : key_p));
  end

  always_comb begin
    stat.empty = (count == '0);
    stat.full = (count == CW'(DEPTH));
    stat.found = (ptr < n) && scan_hit;
    // during a list step the next entry is the one that follows ptr
    stat.last_item = (cmd.op == OpEmit) ? (ptr + CW'(2) == count) : (ptr + 1'b1 == count);
    stat.done = 1'b0;
    case (cmd.op)
      OpFindFree: stat.done = !used[ptr[IW-1:0]] || ptr == CW'(DEPTH - 1);
      OpScan:     stat.done = (ptr >= n) || scan_hit;
      OpRemove:   stat.done = (ptr + 1'b1 >= count);
      OpPlace:    stat.done = (ptr <= CW'(idx));
      default:    stat.done = 1'b0;
    endcase
  end

  // one step of the selected operation per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      count <= '0;
      ptr <= '0;
      found <= 1'b0;
    end else begin
      case (cmd.op)
        OpLoad: begin
          r <= req;
          ptr <= '0;
          found <= 1'b0;
          n <= count;
        end
        OpFindFree: begin
          if (!used[ptr[IW-1:0]]) slot <= ptr[IW-1:0];
          else ptr <= ptr + 1'b1;
        end
        OpWriteSlot: begin
          used[slot] <= 1'b1;
          s_prio[slot] <= key_p;
          s_h[slot] <= r[16:12];
          s_m[slot] <= r[22:17];
          s_s[slot] <= r[28:23];
          s_arr[slot] <= key_t;
          s_tag[slot] <= r[44:29];
          ptr <= '0;
        end
        OpScan: begin
          if (ptr < n && scan_hit) begin
            idx <= ptr[IW-1:0];
            found <= 1'b1;
            if (cmd.match) slot <= cur;
          end else if (ptr >= n) begin
            idx <= ptr[IW-1:0];
          end else ptr <= ptr + 1'b1;
          if (!(ptr < n && !scan_hit) && !cmd.match) ptr <= n;
        end
        // close the gap left by the selected slot, wherever it sits
        OpRemove: begin
          if (ptr + 1'b1 < count) begin
            if (found || cur == slot) begin
              if (cmd.sel_time) t_ord[ptr[IW-1:0]] <= t_ord[IW'(ptr + 1'b1)];
              else p_ord[ptr[IW-1:0]] <= p_ord[IW'(ptr + 1'b1)];
              found <= 1'b1;
            end
            ptr <= ptr + 1'b1;
          end else begin
            n <= count - 1'b1;
            ptr <= '0;
            found <= 1'b0;
          end
        end
        OpPlace: begin
          if (ptr > CW'(idx)) begin
            if (cmd.sel_time) t_ord[ptr[IW-1:0]] <= t_ord[IW'(ptr - 1'b1)];
            else p_ord[ptr[IW-1:0]] <= p_ord[IW'(ptr - 1'b1)];
            ptr <= ptr - 1'b1;
          end else begin
            if (cmd.sel_time) t_ord[idx] <= slot;
            else p_ord[idx] <= slot;
            ptr <= '0;
          end
        end
        OpWriteKey: begin
          if (cmd.sel_time) begin
            s_h[slot] <= r[57:53];
            s_m[slot] <= r[63:58];
            s_s[slot] <= r[69:64];
            s_arr[slot] <= new_t;
          end else s_prio[slot] <= new_p;
          ptr <= '0;
        end
        OpEmit: begin
          if (r_act == ActListP || r_act == ActListT) begin
            slot <= cmd.sel_time ? t_ord[IW'(ptr + 1'b1)] : p_ord[IW'(ptr + 1'b1)];
            ptr <= ptr + 1'b1;
          end
        end
        OpFree: begin
          used[slot] <= 1'b0;
          count <= count - 1'b1;
          n <= count;
          ptr <= '0;
        end
        OpNone: ;
        default: ;
      endcase
      if (cmd.op == OpLoad && req[3:0] != ActInsert)
        slot <= (req[3:0] == ActPopT || req[3:0] == ActPeekT || req[3:0] == ActListT) ?
                t_ord[0] : p_ord[0];
      if (cmd.op == OpPlace && ptr <= CW'(idx) && cmd.sel_time && r_act == ActInsert)
        count <= count + 1'b1;
    end
  end

  assign res_data = {s_tag[slot], s_s[slot], s_m[slot], s_h[slot], 8'(s_prio[slot])};

  `include "dual_order_task_queue_macros.svh"
  `DOTQ_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CW'(DEPTH))
  `DOTQ_ASSERT_IMP(a_used_count, clk, rst, cmd.op == OpLoad, $countones(used) == 32'(count))
  `DOTQ_ASSERT_NEXT(a_free_dec, clk, rst, cmd.op == OpFree, count == $past(count) - 1'b1)
endmodule
`default_nettype wire

// ===== sv/dotq_ctrl.sv =====
`default_nettype none
module dotq_ctrl import dotq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [3:0] in_action,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_status,
  output logic            out_none,
  output logic            out_last,
  output dp_cmd_t         cmd,
  input  wire dp_stat_t   stat
);
  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_FREE_SCAN, S_WRITE, S_SCAN1, S_PLACE1, S_SCAN2, S_PLACE2,
    S_MATCH, S_REMOVE, S_NEWKEY, S_POP_P, S_POP_T, S_FREE, S_OUT, S_EMIT
  } state_t;

  state_t state;
  logic [3:0] act;
  logic side; // 0 priority order, 1 time order

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '{op: OpNone, sel_time: side, use_new: 1'b0, match: 1'b0};
    case (state)
      // request fields are captured at the accepting edge
      S_IDLE:      if (in_valid && in_action <= ActChgT) cmd.op = OpLoad;
      S_FREE_SCAN: cmd.op = OpFindFree;
      S_WRITE:     cmd.op = OpWriteSlot;
      S_SCAN1:     begin cmd.op = OpScan; cmd.sel_time = 1'b0; end
      S_PLACE1:    begin cmd.op = OpPlace; cmd.sel_time = 1'b0; end
      S_SCAN2:     begin cmd.op = OpScan; cmd.sel_time = side; cmd.use_new = (act != ActInsert); end
      S_PLACE2:    begin cmd.op = OpPlace; cmd.sel_time = side; end
      S_MATCH:     begin cmd.op = OpScan; cmd.match = 1'b1; end
      S_REMOVE:    cmd.op = OpRemove;
      S_NEWKEY:    cmd.op = OpWriteKey;
      S_POP_P:     begin cmd.op = OpRemove; cmd.sel_time = 1'b0; end
      S_POP_T:     begin cmd.op = OpRemove; cmd.sel_time = 1'b1; end
      S_FREE:      cmd.op = OpFree;
      S_EMIT:      if (out_ready) cmd.op = OpEmit;
      default:     cmd.op = OpNone;
    endcase
  end

  // sequencer; results wait in S_OUT or S_EMIT until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          act <= in_action;
          side <= (in_action == ActPopT || in_action == ActPeekT ||
                   in_action == ActListT || in_action == ActChgT);
          if (in_action <= ActChgT) state <= S_LOAD;
        end
        S_LOAD: begin
          out_none <= 1'b0; out_last <= 1'b1; out_status <= StOk;
          if (act == ActInsert) begin
            if (stat.full) begin
              out_status <= StFull; out_none <= 1'b1; out_valid <= 1'b1; state <= S_OUT;
            end else begin
              side <= 1'b1; state <= S_FREE_SCAN;
            end
          end else if (stat.empty) begin
            out_status <= StEmpty; out_none <= 1'b1; out_valid <= 1'b1; state <= S_OUT;
          end else if (act == ActPopP || act == ActPopT) begin
            out_valid <= 1'b1; state <= S_OUT;
          end else if (act == ActPeekP || act == ActPeekT) begin
            out_valid <= 1'b1; state <= S_OUT;
          end else if (act == ActListP || act == ActListT) begin
            out_last <= stat.last_item; out_valid <= 1'b1; state <= S_EMIT;
          end else state <= S_MATCH;
        end
        S_FREE_SCAN: if (stat.done) state <= S_WRITE;
        S_WRITE:  state <= S_SCAN1;
        S_SCAN1:  if (stat.done) state <= S_PLACE1;
        S_PLACE1: if (stat.done) state <= S_SCAN2;
        S_SCAN2:  if (stat.done) state <= S_PLACE2;
        S_PLACE2: if (stat.done) begin out_valid <= 1'b1; state <= S_OUT; end
        S_MATCH:  if (stat.done) begin
          if (stat.found) state <= S_REMOVE;
          else begin
            out_status <= StNotFound; out_none <= 1'b1; out_valid <= 1'b1; state <= S_OUT;
          end
        end
        S_REMOVE: if (stat.done) state <= S_NEWKEY;
        S_NEWKEY: state <= S_SCAN2;
        S_POP_P:  if (stat.done) state <= S_POP_T;
        S_POP_T:  if (stat.done) state <= S_FREE;
        S_FREE:   state <= S_IDLE;
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= (!out_none && (act == ActPopP || act == ActPopT)) ? S_POP_P : S_IDLE;
        end
        S_EMIT: if (out_ready) begin
          if (out_last) begin out_valid <= 1'b0; state <= S_IDLE; end
          else out_last <= stat.last_item;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "dual_order_task_queue_macros.svh"
  `DOTQ_ASSERT_IMP(a_ready_idle, clk, rst, out_valid, !in_ready)
  `DOTQ_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire

// ===== sv/dual_order_task_queue.sv =====
`default_nettype none
// Peek, pop and empty/full replies are offered from S_LOAD, entered once the request is taken.
// Insert and change walk their scan and place states; list gives one result per cycle while
// m_tready is high. Pop repairs both orders and frees its slot after its result is taken.
// One request at a time, the next taken once the block is idle again; orders walk 1 entry/cycle.
// Synchronous active-high reset empties the table; slot contents stay unset.
module dual_order_task_queue import dotq_pkg::*; #(
  parameter int DEPTH = DepthDefault,
  parameter int PRIORITY_BITS = PrioBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // action[3:0] priority_req[11:4] hours[16:12] minutes[22:17] seconds[28:23]
  // task_tag[44:29] new_priority[52:45] new_hours[57:53] new_minutes[63:58]
  // new_seconds[69:64], zero fill to 80
  input  wire logic [79:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[1:0] out_priority[9:2] out_hours[14:10] out_minutes[20:15]
  // out_seconds[26:21] out_tag[42:27], zero fill to 48
  output logic [47:0]      m_tdata,
  output logic             m_tlast
);
  dp_cmd_t cmd;
  dp_stat_t stat;
  logic [1:0] st;
  logic none;
  logic [40:0] rd;

  dotq_ctrl u_ctrl (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_action(s_tdata[3:0]),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_status(st), .out_none(none),
    .out_last(m_tlast), .cmd, .stat
  );

  dotq_datapath #(.DEPTH(DEPTH), .PRIORITY_BITS(PRIORITY_BITS)) u_dp (
    .clk, .rst, .cmd, .stat, .req(s_tdata[76:0]), .res_data(rd)
  );

  assign m_tdata = {5'd0, none ? 41'd0 : rd, st};
endmodule
`default_nettype wire
